@@ src/console_command_line_decoder_assert.svh @@
// Assertion macros shared by the console command line decoder RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CONSOLE_COMMAND_LINE_DECODER_ASSERT_SVH
`define CONSOLE_COMMAND_LINE_DECODER_ASSERT_SVH

// Condition holds at every edge out of reset
`define CCLD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication
`define CCLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CCLD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ccld_pkg.sv @@
// Package for the console command line decoder: character constants,
// command codes and the first-character command lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccld_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [4:0]  cmd_code_t;
  typedef logic [15:0] num_t;

  // Characters of interest
  localparam char_t CHAR_CR    = 8'd13;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_EQ    = 8'h3D;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_NUL   = 8'h00;

  // Dense command codes
  localparam cmd_code_t CMD_UNKNOWN  = 5'd0;
  localparam cmd_code_t CMD_LOG      = 5'd1;
  localparam cmd_code_t CMD_DUMP     = 5'd2;
  localparam cmd_code_t CMD_CSV      = 5'd3;
  localparam cmd_code_t CMD_INFO     = 5'd4;
  localparam cmd_code_t CMD_INIT     = 5'd5;
  localparam cmd_code_t CMD_TRIGGER  = 5'd6;
  localparam cmd_code_t CMD_STOP     = 5'd7;
  localparam cmd_code_t CMD_START    = 5'd8;
  localparam cmd_code_t CMD_T        = 5'd9;
  localparam cmd_code_t CMD_F_LOWER  = 5'd10;
  localparam cmd_code_t CMD_D        = 5'd11;
  localparam cmd_code_t CMD_ONE      = 5'd12;
  localparam cmd_code_t CMD_BANG     = 5'd13;
  localparam cmd_code_t CMD_TWO      = 5'd14;
  localparam cmd_code_t CMD_AT       = 5'd15;
  localparam cmd_code_t CMD_GAIN     = 5'd16;
  localparam cmd_code_t CMD_BALANCE  = 5'd17;
  localparam cmd_code_t CMD_FEEDBACK = 5'd18;

  // First character of the line -> command code
  function automatic cmd_code_t cmd_decode(input char_t ch);
    cmd_code_t code;
    case (ch)
      8'h6C:   code = CMD_LOG;       // l
      8'h61:   code = CMD_DUMP;      // a
      8'h41:   code = CMD_CSV;       // A
      8'h69:   code = CMD_INFO;      // i
      8'h49:   code = CMD_INIT;      // I
      8'h47:   code = CMD_TRIGGER;   // G
      8'h73:   code = CMD_STOP;      // s
      8'h71:   code = CMD_START;     // q
      8'h74:   code = CMD_T;         // t
      8'h66:   code = CMD_F_LOWER;   // f
      8'h64:   code = CMD_D;         // d
      8'h31:   code = CMD_ONE;       // 1
      8'h21:   code = CMD_BANG;      // !
      8'h32:   code = CMD_TWO;       // 2
      8'h40:   code = CMD_AT;        // @
      8'h67:   code = CMD_GAIN;      // g
      8'h62:   code = CMD_BALANCE;   // b
      8'h46:   code = CMD_FEEDBACK;  // F
      default: code = CMD_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ src/console_command_line_decoder.sv @@
// Console command line decoder top level: line store, scan sequencer and
// result register. Depends on ccld_pkg, ccld_ram, ccld_acc and the assert header.
//
//   channel | valid      | stall      | word fields
//   --------+------------+------------+------------------------------------------
//   rx in   | rx_valid_i | rx_stall_o | rx_char_i
//   cmd out | cmd_valid_o| cmd_stall_i| command_code_o, first_number_o,
//           |            |            | second_number_o, log_enable_o, acquire_enable_o
//
// An ordinary character is taken whenever no scan runs. A carriage return starts
// a scan of the line store; each character read takes a fetch state (RAM address)
// and then an evaluate state. A balance or feedback channel number that is not
// followed by a separator takes one further evaluate state. The result register
// is loaded when the scan finishes and is valid the cycle after the last evaluate.
// Scanning uses the shared accumulate unit and the single RAM read port.
// rx_stall_o is high during a scan, and for a carriage return while the last
// result still waits in the output register. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "console_command_line_decoder_assert.svh"

module console_command_line_decoder #(
  parameter int LINE_CAPACITY = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rx_valid_i,
  output logic                      rx_stall_o,
  input  wire logic [7:0]           rx_char_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_stall_i,
  output ccld_pkg::cmd_code_t       command_code_o,
  output ccld_pkg::num_t            first_number_o,
  output ccld_pkg::num_t            second_number_o,
  output logic                      log_enable_o,
  output logic                      acquire_enable_o
);
  import ccld_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(LINE_CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EVAL} state_e;
  typedef enum logic [1:0] {P_CMD, P_NUM1, P_NUM2} phase_e;

  state_e    state_q, state_d;
  phase_e    phase_q, phase_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] term_q, term_d;
  logic      two_q, two_d;
  num_t      n1_q, n1_d;
  num_t      n2_q, n2_d;
  cmd_code_t code_q, code_d;
  logic      log_q, log_d;
  logic      acq_q, acq_d;
  logic      out_valid_q, out_valid_d;
  cmd_code_t out_code_q, out_code_d;
  num_t      out_n1_q, out_n1_d;
  num_t      out_n2_q, out_n2_d;
  logic      out_log_q, out_log_d;
  logic      out_acq_q, out_acq_d;

  logic      rx_acc;
  logic      rx_is_cr;
  logic      has_room;
  logic      ram_we;
  char_t     ram_rdata;
  char_t     ch;
  logic      ch_digit;
  logic      ch_sep;
  num_t      acc_in;
  num_t      acc_sum;
  cmd_code_t dec_code;

  // handshake
  assign rx_is_cr   = (rx_char_i == CHAR_CR);
  assign rx_stall_o = (state_q != S_IDLE) || (out_valid_q && rx_is_cr);
  assign rx_acc     = rx_valid_i && !rx_stall_o;
  assign has_room   = (fill_q < CW'(LINE_CAPACITY));
  assign ram_we     = rx_acc && !rx_is_cr && has_room;

  // line store
  ccld_ram #(
    .Width (8),
    .Depth (LINE_CAPACITY)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (rx_char_i),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // terminator slot reads as NUL
  assign ch       = (pos_q == term_q) ? CHAR_NUL : ram_rdata;
  assign ch_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign ch_sep   = (ch == CHAR_SPACE) || (ch == CHAR_EQ);
  assign dec_code = cmd_decode(ch);

  // shared accumulate unit
  assign acc_in = (phase_q == P_NUM2) ? n2_q : n1_q;

  ccld_acc u_acc (
    .acc_i   (acc_in),
    .digit_i (ch[3:0]),
    .sum_o   (acc_sum)
  );

  // next-state logic
  always_comb begin
    logic finish;
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    term_d      = term_q;
    two_d       = two_q;
    n1_d        = n1_q;
    n2_d        = n2_q;
    code_d      = code_q;
    log_d       = log_q;
    acq_d       = acq_q;
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_n1_d    = out_n1_q;
    out_n2_d    = out_n2_q;
    out_log_d   = out_log_q;
    out_acq_d   = out_acq_q;
    finish      = 1'b0;

    if (out_valid_q && !cmd_stall_i) begin
      out_valid_d = 1'b0;
    end

    // line fill and line end
    if (rx_acc) begin
      if (rx_is_cr) begin
        term_d  = has_room ? fill_q[AW-1:0] : AW'(LINE_CAPACITY - 1);
        fill_d  = '0;
        pos_d   = '0;
        phase_d = P_CMD;
        two_d   = 1'b0;
        n1_d    = '0;
        n2_d    = '0;
        state_d = S_FETCH;
      end else if (has_room) begin
        fill_d = fill_q + CW'(1);
      end
    end

    // scan sequencer
    case (state_q)
      S_FETCH: state_d = S_EVAL;
      S_EVAL: begin
        case (phase_q)
          P_CMD: begin
            code_d = dec_code;
            if (dec_code == CMD_LOG) begin
              log_d = ~log_q;
            end
            if (dec_code == CMD_STOP) begin
              acq_d = 1'b0;
            end
            if (dec_code == CMD_START) begin
              acq_d = 1'b1;
            end
            if (dec_code == CMD_GAIN || dec_code == CMD_BALANCE ||
                dec_code == CMD_FEEDBACK) begin
              two_d   = (dec_code != CMD_GAIN);
              phase_d = P_NUM1;
              pos_d   = pos_q + AW'(1);
              state_d = S_FETCH;
            end else begin
              finish = 1'b1;
            end
          end
          P_NUM1: begin
            if (ch_digit) begin
              n1_d    = acc_sum;
              pos_d   = pos_q + AW'(1);
              state_d = S_FETCH;
            end else if (two_q) begin
              phase_d = P_NUM2;
              if (ch_sep) begin
                pos_d   = pos_q + AW'(1);
                state_d = S_FETCH;
              end
            end else begin
              finish = 1'b1;
            end
          end
          P_NUM2: begin
            if (ch_digit) begin
              n2_d    = acc_sum;
              pos_d   = pos_q + AW'(1);
              state_d = S_FETCH;
            end else begin
              finish = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      default: ;
    endcase

    // load result word
    if (finish) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      out_code_d  = code_d;
      out_n1_d    = n1_d;
      out_n2_d    = n2_d;
      out_log_d   = log_d;
      out_acq_d   = acq_d;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_CMD;
      fill_q      <= '0;
      pos_q       <= '0;
      term_q      <= '0;
      two_q       <= 1'b0;
      n1_q        <= '0;
      n2_q        <= '0;
      code_q      <= CMD_UNKNOWN;
      log_q       <= 1'b1;
      acq_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_code_q  <= CMD_UNKNOWN;
      out_n1_q    <= '0;
      out_n2_q    <= '0;
      out_log_q   <= 1'b1;
      out_acq_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      term_q      <= term_d;
      two_q       <= two_d;
      n1_q        <= n1_d;
      n2_q        <= n2_d;
      code_q      <= code_d;
      log_q       <= log_d;
      acq_q       <= acq_d;
      out_valid_q <= out_valid_d;
      out_code_q  <= out_code_d;
      out_n1_q    <= out_n1_d;
      out_n2_q    <= out_n2_d;
      out_log_q   <= out_log_d;
      out_acq_q   <= out_acq_d;
    end
  end

  assign cmd_valid_o      = out_valid_q;
  assign command_code_o   = out_code_q;
  assign first_number_o   = out_n1_q;
  assign second_number_o  = out_n2_q;
  assign log_enable_o     = out_log_q;
  assign acquire_enable_o = out_acq_q;

  // checks
  `CCLD_ASSERT(a_fill_bound, fill_q <= CW'(LINE_CAPACITY), "fill count above capacity")
  `CCLD_ASSERT_IMP(a_scan_in_line, state_q != S_IDLE, pos_q <= term_q, "scan passed terminator")
  `CCLD_ASSERT_NXT(a_cr_starts_scan, rx_acc && rx_is_cr, state_q == S_FETCH, "line end not scanned")
  `CCLD_ASSERT_IMP(a_result_from_scan, $rose(out_valid_q), $past(state_q) == S_EVAL, "result without scan")

endmodule

`default_nettype wire

@@ src/ccld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module ccld_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/ccld_acc.sv @@
// Shared decimal accumulate unit: acc * 10 + digit, modulo 65536.
// Depends on ccld_pkg for the number type.
`timescale 1ns / 1ps
`default_nettype none

module ccld_acc (
  input  wire ccld_pkg::num_t acc_i,
  input  wire logic [3:0] digit_i,
  output ccld_pkg::num_t sum_o
);
  import ccld_pkg::*;

  num_t times8;
  num_t times2;

  // x*10 = x*8 + x*2, upper bits fall off
  assign times8 = {acc_i[12:0], 3'b000};
  assign times2 = {acc_i[14:0], 1'b0};
  assign sum_o  = times8 + times2 + {12'd0, digit_i};

endmodule

`default_nettype wire
